[hw/rtl/ri_pkg.sv]
// ----------------------------------------------------------------------------
// ri_pkg: shared definitions for the radical inverse unit
// Field widths, internal datapath widths, sequencer states, the operation
// codes of the shared datapath and the control and status structs.
// ----------------------------------------------------------------------------
package ri_pkg;

	// Field widths of the input and result items.
	localparam int INDEX_BITS    = 31;
	localparam int RADIX_BITS    = 16;
	localparam int FRACTION_BITS = 32;

	// Mirrored numerator and radix power both stay at or below index * radix.
	localparam int PROD_BITS = INDEX_BITS + RADIX_BITS;
	// Shared compare/subtract unit works on a shifted numerator.
	localparam int SUB_BITS  = PROD_BITS + 1;
	// Full multiplier product before truncation.
	localparam int MUL_BITS  = PROD_BITS + RADIX_BITS;

	// Step counter covers the longer of the two division loops.
	localparam int STEP_MAX  = (INDEX_BITS > FRACTION_BITS) ? INDEX_BITS : FRACTION_BITS;
	localparam int CNT_BITS  = $clog2(STEP_MAX);

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIGIT,
		ST_MUL_M,
		ST_MUL_P,
		ST_FRAC,
		ST_FINISH
	} state_t;

	// Operations of the shared datapath.
	typedef enum logic [2:0] {
		OP_NONE,
		OP_DIV_DIGIT,
		OP_MUL_M,
		OP_MUL_P,
		OP_DIV_FRAC
	} dp_op_t;

	// Sequencer to datapath.
	typedef struct packed {
		logic   load;
		dp_op_t op;
	} dp_ctrl_t;

	// Datapath to sequencer.
	typedef struct packed {
		logic idx_zero;
	} dp_stat_t;

endpackage

[hw/rtl/ri_if.sv]
// ----------------------------------------------------------------------------
// ri_if: item channels of the radical inverse unit
// Valid/ready channels for the sample items going in and the results
// coming out.
// ----------------------------------------------------------------------------

// Input item channel: one sample index and its radix.
interface ri_in_if
	import ri_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic [INDEX_BITS-1:0] sample_index;
	logic [RADIX_BITS-1:0] radix;

	modport source (output valid, output sample_index, output radix, input ready);
	modport sink   (input valid, input sample_index, input radix, output ready);
endinterface

// Result item channel: fraction and bad radix flag.
interface ri_out_if
	import ri_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic [FRACTION_BITS-1:0] fraction;
	logic                     bad_radix;

	modport source (output valid, output fraction, output bad_radix, input ready);
	modport sink   (input valid, input fraction, input bad_radix, output ready);
endinterface

[hw/rtl/ri_datapath.sv]
// ----------------------------------------------------------------------------
// ri_datapath: shared arithmetic of the radical inverse unit
// One compare/subtract unit serves both the digit extraction (index divided
// by radix, one quotient bit a cycle) and the final fraction division.
// A multiplier builds the mirrored numerator and the radix power.
// ----------------------------------------------------------------------------
module ri_datapath
	import ri_pkg::*;
(
	input  logic                     clk,
	input  dp_ctrl_t                 ctrl,
	input  logic [INDEX_BITS-1:0]    sample_index,
	input  logic [RADIX_BITS-1:0]    radix,
	output dp_stat_t                 stat,
	output logic [FRACTION_BITS-1:0] fraction,
	output logic                     bad_radix
);

	logic [INDEX_BITS-1:0]    idx_q;
	logic [RADIX_BITS-1:0]    base_q;
	logic [RADIX_BITS-1:0]    digit_q;
	logic [PROD_BITS-1:0]     num_q;
	logic [PROD_BITS-1:0]     den_q;
	logic [FRACTION_BITS-1:0] frac_q;
	logic                     bad_q;

	logic [SUB_BITS-1:0]      sub_a;
	logic [SUB_BITS-1:0]      sub_b;
	logic [SUB_BITS:0]        sub_diff;
	logic                     sub_ge;
	logic [SUB_BITS-1:0]      sub_res;

	logic [PROD_BITS-1:0]     mul_a;
	logic [MUL_BITS-1:0]      mul_full;
	logic [PROD_BITS-1:0]     mul_sum;

	// Shared compare/subtract: one restoring division step.
	always_comb begin
		sub_a = '0;
		sub_b = '0;
		case (ctrl.op)
			OP_DIV_DIGIT: begin
				sub_a = SUB_BITS'({digit_q, idx_q[INDEX_BITS-1]});
				sub_b = SUB_BITS'(base_q);
			end
			OP_DIV_FRAC: begin
				sub_a = {num_q, 1'b0};
				sub_b = {1'b0, den_q};
			end
			default: begin
			end
		endcase
		sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
		sub_ge   = ~sub_diff[SUB_BITS];
		sub_res  = sub_ge ? sub_diff[SUB_BITS-1:0] : sub_a;
	end

	// Multiply by the radix; the numerator also takes the new digit.
	always_comb begin
		mul_a    = (ctrl.op == OP_MUL_P) ? den_q : num_q;
		mul_full = MUL_BITS'(mul_a) * MUL_BITS'(base_q);
		mul_sum  = mul_full[PROD_BITS-1:0] +
			((ctrl.op == OP_MUL_M) ? PROD_BITS'(digit_q) : '0);
	end

	// Working registers.
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			idx_q   <= sample_index;
			base_q  <= radix;
			digit_q <= '0;
			num_q   <= '0;
			den_q   <= PROD_BITS'(1);
			frac_q  <= '0;
			bad_q   <= (radix[RADIX_BITS-1:1] == '0);
		end else begin
			case (ctrl.op)
				OP_DIV_DIGIT: begin
					digit_q <= sub_res[RADIX_BITS-1:0];
					idx_q   <= {idx_q[INDEX_BITS-2:0], sub_ge};
				end
				OP_DIV_FRAC: begin
					num_q  <= sub_res[PROD_BITS-1:0];
					frac_q <= {frac_q[FRACTION_BITS-2:0], sub_ge};
				end
				OP_MUL_M: begin
					num_q <= mul_sum;
				end
				OP_MUL_P: begin
					den_q   <= mul_full[PROD_BITS-1:0];
					digit_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	assign stat.idx_zero = (idx_q == '0);
	assign fraction      = frac_q;
	assign bad_radix     = bad_q;

endmodule

[hw/rtl/ri_ctrl.sv]
// ----------------------------------------------------------------------------
// ri_ctrl: sequencer of the radical inverse unit
// Steps the shared datapath through digit division, numerator and power
// updates for each digit, then the final fraction division.
// ----------------------------------------------------------------------------
module ri_ctrl
	import ri_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     in_zero,
	input  logic     in_bad,
	input  logic     out_free,
	input  dp_stat_t stat,
	output logic     in_ready,
	output logic     out_load,
	output dp_ctrl_t ctrl
);

	state_t              state_q;
	state_t              state_d;
	logic [CNT_BITS-1:0] cnt_q;
	logic [CNT_BITS-1:0] cnt_d;

	// State and step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	// Next state and datapath commands.
	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		in_ready  = 1'b0;
		out_load  = 1'b0;
		ctrl.load = 1'b0;
		ctrl.op   = OP_NONE;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctrl.load = 1'b1;
					// A zero index or a bad radix gives zero at once.
					if (in_zero || in_bad) begin
						state_d = ST_FINISH;
					end else begin
						state_d = ST_DIGIT;
						cnt_d   = CNT_BITS'(INDEX_BITS - 1);
					end
				end
			end
			ST_DIGIT: begin
				ctrl.op = OP_DIV_DIGIT;
				if (cnt_q == '0) begin
					state_d = ST_MUL_M;
				end else begin
					cnt_d = cnt_q - 1'b1;
				end
			end
			ST_MUL_M: begin
				ctrl.op = OP_MUL_M;
				state_d = ST_MUL_P;
			end
			ST_MUL_P: begin
				ctrl.op = OP_MUL_P;
				if (stat.idx_zero) begin
					state_d = ST_FRAC;
					cnt_d   = CNT_BITS'(FRACTION_BITS - 1);
				end else begin
					state_d = ST_DIGIT;
					cnt_d   = CNT_BITS'(INDEX_BITS - 1);
				end
			end
			ST_FRAC: begin
				ctrl.op = OP_DIV_FRAC;
				if (cnt_q == '0) begin
					state_d = ST_FINISH;
				end else begin
					cnt_d = cnt_q - 1'b1;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

[hw/rtl/radical_inverse_unit.sv]
// ----------------------------------------------------------------------------
// radical_inverse_unit: Halton radical inverse
// Mirrors the base-radix digits of a sample index about the radix point and
// returns the value as an unsigned 0.32 fraction, rounded down.
//
//   channel  dir  fields                    handshake
//   req      in   sample_index, radix       valid/ready
//   rsp      out  fraction, bad_radix       valid/ready
//
// For each base-radix digit the index is divided by the radix bit-serially
// on the shared compare/subtract unit, followed by two multiply steps; the
// fraction is then a bit-serial division of the mirrored numerator by the
// radix power. A zero index or a radix below two skips these steps and
// goes straight to the result.
// One item is worked on at a time; req.ready is high only while idle.
// The result register holds a finished item while the next one is worked on.
// Reset clears the sequencer and the result valid flag.
// ----------------------------------------------------------------------------
module radical_inverse_unit
	import ri_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	ri_in_if.sink      req,
	ri_out_if.source   rsp
);

	dp_ctrl_t                 ctrl;
	dp_stat_t                 stat;
	logic                     in_zero;
	logic                     in_bad;
	logic                     out_free;
	logic                     out_load;
	logic [FRACTION_BITS-1:0] dp_fraction;
	logic                     dp_bad;

	logic                     out_valid_q;
	logic [FRACTION_BITS-1:0] fraction_q;
	logic                     bad_radix_q;

	// Shortcut checks on the incoming item.
	assign in_zero  = (req.sample_index == '0);
	assign in_bad   = (req.radix[RADIX_BITS-1:1] == '0);
	assign out_free = ~out_valid_q | rsp.ready;

	ri_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_zero  (in_zero),
		.in_bad   (in_bad),
		.out_free (out_free),
		.stat     (stat),
		.in_ready (req.ready),
		.out_load (out_load),
		.ctrl     (ctrl)
	);

	ri_datapath u_datapath (
		.clk          (clk),
		.ctrl         (ctrl),
		.sample_index (req.sample_index),
		.radix        (req.radix),
		.stat         (stat),
		.fraction     (dp_fraction),
		.bad_radix    (dp_bad)
	);

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (out_load) begin
			fraction_q  <= dp_fraction;
			bad_radix_q <= dp_bad;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.fraction  = fraction_q;
	assign rsp.bad_radix = bad_radix_q;

endmodule
